// File: rtl/core/lfcm_pkg.sv
// Package with the shared constants, sine table and item type of the corridor minimum block.
`timescale 1ns / 1ps
package lfcm_pkg;

  localparam int unsigned SCAN_BEAMS        = 360;
  localparam int unsigned HALF_SECTOR_BEAMS = 90;
  localparam int unsigned TABLE_LAST        = 90;
  localparam int unsigned FRAC_BITS         = 15;

  localparam logic [15:0] FORWARD_LIMIT_RESET = 16'd180;
  localparam logic [15:0] HALF_WIDTH_RESET    = 16'd110;
  localparam logic [15:0] NO_HIT_MM           = 16'hFFFF;

  typedef enum logic [0:0] {
    REG_FORWARD_LIMIT = 1'b0,
    REG_HALF_WIDTH    = 1'b1
  } reg_index_t;

  localparam logic [15:0] SIN_Q15 [0:90] = '{
    16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,  16'd2856,  16'd3425,
    16'd3993,  16'd4560,  16'd5126,  16'd5690,  16'd6252,  16'd6813,  16'd7371,
    16'd7927,  16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668, 16'd11207,
    16'd11743, 16'd12275, 16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876,
    16'd15384, 16'd15886, 16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
    16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498,
    16'd21926, 16'd22348, 16'd22763, 16'd23170, 16'd23571, 16'd23965, 16'd24351,
    16'd24730, 16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510, 16'd26842,
    16'd27166, 16'd27482, 16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932,
    16'd29197, 16'd29452, 16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
    16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499, 16'd31651, 16'd31795,
    16'd31928, 16'd32052, 16'd32166, 16'd32270, 16'd32365, 16'd32449, 16'd32524,
    16'd32588, 16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763, 16'd32768
  };

  function automatic logic [15:0] sin_lookup(input logic [6:0] deg);
    logic [15:0] val;
    val = 16'd0;
    if (deg <= 7'(TABLE_LAST)) begin
      val = SIN_Q15[deg];
    end
    return val;
  endfunction

  typedef struct packed {
    logic        used;
    logic        last;
    logic [15:0] range_mm;
    logic [15:0] sin_q;
    logic [15:0] cos_q;
  } beam_item_t;

endpackage

// File: rtl/core/lfcm_if.sv
// Valid/ready channel interfaces for lidar samples and corridor results.
`timescale 1ns / 1ps
interface lfcm_sample_if;
  logic        valid;
  logic        ready;
  logic [8:0]  scan_index;
  logic [15:0] range_mm;
  logic        scan_last;
  modport source (output valid, scan_index, range_mm, scan_last, input ready);
  modport sink (input valid, scan_index, range_mm, scan_last, output ready);
endinterface

interface lfcm_result_if;
  logic        valid;
  logic        ready;
  logic        obstacle_found;
  logic [15:0] nearest_mm;
  modport source (output valid, obstacle_found, nearest_mm, input ready);
  modport sink (input valid, obstacle_found, nearest_mm, output ready);
endinterface

// File: rtl/core/lfcm_front.sv
// Front stage: accepts samples, maps the beam to an angle and fetches sine and cosine.
`timescale 1ns / 1ps
module lfcm_front
  import lfcm_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  lfcm_sample_if.sink   sample,
  output logic          push_valid,
  output beam_item_t    push_item,
  input  logic          push_ready
);

  logic       used;
  logic [6:0] deg;
  logic       hold;

  always_comb begin
    used = 1'b0;
    deg  = 7'd0;
    if (sample.scan_index < 9'(HALF_SECTOR_BEAMS)) begin
      used = 1'b1;
      deg  = sample.scan_index[6:0];
    end else if (sample.scan_index >= 9'(SCAN_BEAMS - HALF_SECTOR_BEAMS) &&
                 sample.scan_index < 9'(SCAN_BEAMS)) begin
      used = 1'b1;
      deg  = 7'(9'(SCAN_BEAMS - 1) - sample.scan_index);
    end
  end

  assign hold         = push_valid && !push_ready;
  assign sample.ready = !hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      push_valid <= 1'b0;
    end else if (!hold) begin
      push_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold && sample.valid) begin
      push_item.used     <= used;
      push_item.last     <= sample.scan_last;
      push_item.range_mm <= sample.range_mm;
      push_item.sin_q    <= sin_lookup(deg);
      push_item.cos_q    <= sin_lookup(7'(TABLE_LAST) - deg);
    end
  end

endmodule

// File: rtl/core/lfcm_fifo.sv
// Four-entry queue that decouples the front stage from the back stage.
`timescale 1ns / 1ps
module lfcm_fifo
  import lfcm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  input  beam_item_t push_item,
  output logic       push_ready,
  output logic       pop_valid,
  output beam_item_t pop_item,
  input  logic       pop_ready
);

  beam_item_t  entries [0:3];
  logic [1:0]  wr_ptr;
  logic [1:0]  rd_ptr;
  logic [2:0]  count;
  logic        do_push;
  logic        do_pop;

  assign push_ready = (count != 3'd4);
  assign pop_valid  = (count != 3'd0);
  assign pop_item   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      if (do_push && !do_pop) begin
        count <= count + 3'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

// File: rtl/core/lfcm_back.sv
// Back stage: forms both products, tests the corridor and keeps the running minimum.
`timescale 1ns / 1ps
module lfcm_back
  import lfcm_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          pop_valid,
  input  beam_item_t    pop_item,
  output logic          pop_ready,
  input  logic [15:0]   forward_limit_mm,
  input  logic [15:0]   half_width_mm,
  lfcm_result_if.source result
);

  logic        p_valid;
  logic        p_used;
  logic        p_last;
  logic [31:0] p_lat;
  logic [31:0] p_fwd;

  logic [15:0] running_min;
  logic        hit_seen;
  logic [15:0] running_min_next;
  logic        hit_seen_next;
  logic        qualify;
  logic [15:0] fwd_mm;
  logic        acc_take;

  assign acc_take  = p_valid && (!p_last || !result.valid || result.ready);
  assign pop_ready = !p_valid || acc_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (pop_ready) begin
      p_valid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_ready && pop_valid) begin
      p_used <= pop_item.used;
      p_last <= pop_item.last;
      p_lat  <= {16'd0, pop_item.range_mm} * {16'd0, pop_item.sin_q};
      p_fwd  <= {16'd0, pop_item.range_mm} * {16'd0, pop_item.cos_q};
    end
  end

  always_comb begin
    fwd_mm  = p_fwd[30:15];
    qualify = p_used &&
              (p_lat < {1'b0, half_width_mm, 15'd0}) &&
              (p_fwd < {1'b0, forward_limit_mm, 15'd0});
    running_min_next = running_min;
    if (qualify && fwd_mm < running_min) begin
      running_min_next = fwd_mm;
    end
    hit_seen_next = hit_seen || qualify;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_min <= NO_HIT_MM;
      hit_seen    <= 1'b0;
    end else if (acc_take) begin
      if (p_last) begin
        running_min <= NO_HIT_MM;
        hit_seen    <= 1'b0;
      end else begin
        running_min <= running_min_next;
        hit_seen    <= hit_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (acc_take && p_last) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_take && p_last) begin
      result.obstacle_found <= hit_seen_next;
      result.nearest_mm     <= hit_seen_next ? running_min_next : NO_HIT_MM;
    end
  end

endmodule

// File: rtl/core/lidar_front_corridor_min.sv
// Top level of the front corridor nearest-obstacle finder for a lidar scan.
//
//   Port     Direction  Content
//   sample   sink       scan_index, range_mm, scan_last
//   result   source     obstacle_found, nearest_mm (one item per scan)
//   wr_*     in         register writes: index 0 forward limit, 1 half width
//
// One sample is accepted every cycle unless a full queue holds the front. After the last
// sample, the result passes front register, queue, multiply register and output register.
// The two 16 by 16 multiplies share one stage; the minimum update takes the next.
// Reset is synchronous and restores the default limits and an empty scan.
// A stalled result holds the back stage, and the four-entry queue keeps the front running.
`timescale 1ns / 1ps
module lidar_front_corridor_min
  import lfcm_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  lfcm_sample_if.sink   sample,
  lfcm_result_if.source result,
  input  logic          wr_en,
  input  reg_index_t    wr_index,
  input  logic [15:0]   wr_data
);

  logic [15:0] forward_limit_mm;
  logic [15:0] half_width_mm;
  logic        push_valid;
  logic        push_ready;
  beam_item_t  push_item;
  logic        pop_valid;
  logic        pop_ready;
  beam_item_t  pop_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      forward_limit_mm <= FORWARD_LIMIT_RESET;
      half_width_mm    <= HALF_WIDTH_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_FORWARD_LIMIT: forward_limit_mm <= wr_data;
        REG_HALF_WIDTH:    half_width_mm    <= wr_data;
        default:           ;
      endcase
    end
  end

  lfcm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .sample     (sample),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  lfcm_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready)
  );

  lfcm_back u_back (
    .clk              (clk),
    .rst              (rst),
    .pop_valid        (pop_valid),
    .pop_item         (pop_item),
    .pop_ready        (pop_ready),
    .forward_limit_mm (forward_limit_mm),
    .half_width_mm    (half_width_mm),
    .result           (result)
  );

endmodule
